// ===== hdl/bbpq_pkg.sv =====
// shared types, constants and helpers for the biased block palette quantizer
// no dependencies; imported by bbpq_ctrl, bbpq_datapath and the core top level

package bbpq_pkg;

    // item geometry
    localparam int NUM_COLORS = 4;
    localparam int NUM_PIXELS = 4;
    localparam int NUM_CHANNELS = 3;
    localparam int CH_W = 8;
    localparam int RGB_W = 24;
    localparam int COORD_W = 7;
    localparam int CODE_W = 2;
    localparam int PIX_SEL_W = 2;

    // arithmetic widths
    localparam int SQ_W = 16;
    localparam int SQ_SUM_W = 18;
    localparam int DIST_W = 20;
    localparam int RES_W = 22;
    localparam int ROOT_W = 10;
    localparam int CNT_W = 14;
    localparam int TOTAL_W = 15;
    localparam int ERR_W = 12;
    localparam int BYTE_W = 12;
    localparam int SHIFT_W = 3;

    // sequencing
    localparam int ROOT_STEPS = 11;
    localparam int STEP_W = 4;
    localparam int BIAS_SHIFT = 4;

    // constant values
    localparam logic [RES_W-1:0] ROOT_ONE_INIT = RES_W'(1) << (2 * (ROOT_STEPS - 1));
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
    localparam logic [TOTAL_W-1:0] ERR_MAX = TOTAL_W'({ERR_W{1'b1}});

    typedef logic [RGB_W-1:0] rgb_t;

    localparam rgb_t PALETTE_RESET [NUM_COLORS] = '{
        24'h00FF00, 24'hFFFF00, 24'h0000FF, 24'hFF0000
    };

    // controller to datapath commands
    typedef struct packed {
        logic                 load;
        logic                 dist_en;
        logic [PIX_SEL_W-1:0] pix_sel;
        logic                 root_step;
        logic                 total_en;
        logic                 out_load;
    } dp_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic out_free;
    } dp_status_t;

    // squared absolute difference of two channel values
    function automatic logic [SQ_W-1:0] abs_square(input logic [CH_W-1:0] a,
                                                   input logic [CH_W-1:0] b);
        logic [CH_W-1:0] d;
        d = (a >= b) ? (a - b) : (b - a);
        return SQ_W'(d) * SQ_W'(d);
    endfunction

endpackage

// ===== hdl/bbpq_ctrl.sv =====
// sequencer for the block quantizer: accept, distance, root, total, deliver
// depends on bbpq_pkg for the command and status structs

module bbpq_ctrl
    import bbpq_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_DIST  = 5'b00010,
        S_ROOT  = 5'b00100,
        S_TOTAL = 5'b01000,
        S_DONE  = 5'b10000
    } state_t;

    localparam logic [STEP_W-1:0] DIST_LAST = STEP_W'(NUM_PIXELS - 1);
    localparam logic [STEP_W-1:0] ROOT_LAST = STEP_W'(ROOT_STEPS - 1);

    state_t            state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;

    // input side is open only between items
    assign in_stall = (state_reg != S_IDLE);

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        cmd.pix_sel = step_reg[PIX_SEL_W-1:0];
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    step_next  = '0;
                    state_next = S_DIST;
                end
            end
            S_DIST:
            begin
                cmd.dist_en = 1'b1;
                if (step_reg == DIST_LAST)
                begin
                    step_next  = '0;
                    state_next = S_ROOT;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            S_ROOT:
            begin
                cmd.root_step = 1'b1;
                if (step_reg == ROOT_LAST)
                begin
                    step_next  = '0;
                    state_next = S_TOTAL;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            S_TOTAL:
            begin
                cmd.total_en = 1'b1;
                state_next   = S_DONE;
            end
            S_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    // the totals are formed only after a full run of root steps
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_TOTAL) |-> ($past(state_reg) == S_ROOT && $past(step_reg) == ROOT_LAST))
        else $error("totals formed before the root iterations finished");

    // an accepted word always starts the distance phase at pixel zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == S_DIST && step_reg == '0))
        else $error("accepted word did not start the distance phase");

    // delivery never happens while the result slot is held
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> status.out_free)
        else $error("result loaded into a held output slot");

endmodule

// ===== hdl/bbpq_datapath.sv =====
// datapath: palette registers, distance lanes, square root lanes, usage counters, output
// depends on bbpq_pkg for widths, constants, command struct and abs_square

module bbpq_datapath
    import bbpq_pkg::*;
#(
    parameter int BLOCKS_PER_ROW = 128
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic [1:0]           cfg_index,
    input  logic [RGB_W-1:0]     cfg_data,
    input  logic [RGB_W-1:0]     pixel_top_left,
    input  logic [RGB_W-1:0]     pixel_top_right,
    input  logic [RGB_W-1:0]     pixel_bottom_left,
    input  logic [RGB_W-1:0]     pixel_bottom_right,
    input  logic [COORD_W-1:0]   block_column,
    input  logic [COORD_W-1:0]   block_row,
    input  logic                 frame_start,
    input  dp_cmd_t              cmd,
    output dp_status_t           status,
    input  logic                 out_stall,
    output logic                 out_valid,
    output logic [CODE_W-1:0]    color_code,
    output logic [BYTE_W-1:0]    byte_index,
    output logic [SHIFT_W-1:0]   bit_shift,
    output logic [ERR_W-1:0]     biased_error
);

    localparam int POS_RAW_W = COORD_W + 1 + $clog2(BLOCKS_PER_ROW);
    localparam int POS_W = (POS_RAW_W > BYTE_W + 2) ? POS_RAW_W : BYTE_W + 2;

    rgb_t                palette_reg [NUM_COLORS];
    rgb_t                pix_reg [NUM_PIXELS];
    logic [COORD_W-1:0]  col_reg;
    logic [COORD_W-1:0]  row_reg;
    logic [DIST_W-1:0]   rem_reg [NUM_COLORS];
    logic [RES_W-1:0]    res_reg [NUM_COLORS];
    logic [RES_W-1:0]    one_reg;
    logic [TOTAL_W-1:0]  total_reg [NUM_COLORS];
    logic [CNT_W-1:0]    count_reg [NUM_COLORS];
    logic                out_valid_reg;
    logic [CODE_W-1:0]   code_reg;
    logic [BYTE_W-1:0]   byte_reg;
    logic [SHIFT_W-1:0]  shift_reg;
    logic [ERR_W-1:0]    err_reg;

    rgb_t                cur_pix;
    logic [SQ_SUM_W-1:0] sq_sum [NUM_COLORS];
    logic [RES_W-1:0]    trial [NUM_COLORS];
    logic                take [NUM_COLORS];
    logic [ROOT_W-1:0]   root_rnd [NUM_COLORS];
    logic [CODE_W-1:0]   best_idx;
    logic [TOTAL_W-1:0]  best_total;
    logic [POS_W-1:0]    pos;

    assign status.out_free = !out_valid_reg || !out_stall;

    // palette registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < NUM_COLORS; c++)
            begin
                palette_reg[c] <= PALETTE_RESET[c];
            end
        end
        else if (cfg_write)
        begin
            palette_reg[cfg_index] <= cfg_data;
        end
    end

    // capture the input word
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            pix_reg[0] <= pixel_top_left;
            pix_reg[1] <= pixel_top_right;
            pix_reg[2] <= pixel_bottom_left;
            pix_reg[3] <= pixel_bottom_right;
            col_reg    <= block_column;
            row_reg    <= block_row;
        end
    end

    // one pixel against all four palette colors per cycle
    assign cur_pix = pix_reg[cmd.pix_sel];

    always_comb
    begin
        for (int c = 0; c < NUM_COLORS; c++)
        begin
            sq_sum[c] = '0;
            for (int ch = 0; ch < NUM_CHANNELS; ch++)
            begin
                sq_sum[c] = sq_sum[c] + SQ_SUM_W'(abs_square(
                    cur_pix[RGB_W-1-CH_W*ch -: CH_W],
                    palette_reg[c][RGB_W-1-CH_W*ch -: CH_W]));
            end
        end
    end

    // one restoring root digit per lane and cycle
    always_comb
    begin
        for (int c = 0; c < NUM_COLORS; c++)
        begin
            trial[c] = res_reg[c] + one_reg;
            take[c]  = (RES_W'(rem_reg[c]) >= trial[c]);
        end
    end

    // distance accumulation, then the remainder and root of each lane
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            one_reg <= ROOT_ONE_INIT;
            for (int c = 0; c < NUM_COLORS; c++)
            begin
                rem_reg[c] <= '0;
                res_reg[c] <= '0;
            end
        end
        else if (cmd.dist_en)
        begin
            for (int c = 0; c < NUM_COLORS; c++)
            begin
                rem_reg[c] <= rem_reg[c] + DIST_W'(sq_sum[c]);
            end
        end
        else if (cmd.root_step)
        begin
            one_reg <= one_reg >> 2;
            for (int c = 0; c < NUM_COLORS; c++)
            begin
                if (take[c])
                begin
                    rem_reg[c] <= rem_reg[c] - DIST_W'(trial[c]);
                    res_reg[c] <= (res_reg[c] >> 1) + one_reg;
                end
                else
                begin
                    res_reg[c] <= res_reg[c] >> 1;
                end
            end
        end
    end

    // round to nearest and add the usage bias
    always_comb
    begin
        for (int c = 0; c < NUM_COLORS; c++)
        begin
            root_rnd[c] = res_reg[c][ROOT_W-1:0]
                        + ROOT_W'(RES_W'(rem_reg[c]) > res_reg[c]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.total_en)
        begin
            for (int c = 0; c < NUM_COLORS; c++)
            begin
                total_reg[c] <= TOTAL_W'(root_rnd[c]) + TOTAL_W'(count_reg[c] >> BIAS_SHIFT);
            end
        end
    end

    // lowest total wins, lower index on a tie
    always_comb
    begin
        best_idx   = '0;
        best_total = total_reg[0];
        for (int c = 1; c < NUM_COLORS; c++)
        begin
            if (total_reg[c] < best_total)
            begin
                best_idx   = CODE_W'(c);
                best_total = total_reg[c];
            end
        end
    end

    // linear block position for packing
    assign pos = POS_W'(row_reg) * POS_W'(BLOCKS_PER_ROW) + POS_W'(col_reg);

    // usage counters: cleared at frame start, winner bumped on delivery
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < NUM_COLORS; c++)
            begin
                count_reg[c] <= '0;
            end
        end
        else if (cmd.load && frame_start)
        begin
            for (int c = 0; c < NUM_COLORS; c++)
            begin
                count_reg[c] <= '0;
            end
        end
        else if (cmd.out_load && count_reg[best_idx] != CNT_MAX)
        begin
            count_reg[best_idx] <= count_reg[best_idx] + 1'b1;
        end
    end

    // output word valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // output word payload
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            code_reg  <= best_idx;
            byte_reg  <= pos[BYTE_W+1:2];
            shift_reg <= {~pos[1:0], 1'b0};
            err_reg   <= (best_total > ERR_MAX) ? ERR_W'(ERR_MAX) : best_total[ERR_W-1:0];
        end
    end

    assign out_valid    = out_valid_reg;
    assign color_code   = code_reg;
    assign byte_index   = byte_reg;
    assign bit_shift    = shift_reg;
    assign biased_error = err_reg;

    // after the last digit each lane holds a floor root: remainder at most twice the root
    for (genvar g = 0; g < NUM_COLORS; g++)
    begin : g_root_chk
        assert property (@(posedge clk) disable iff (!rst_n)
            cmd.total_en |-> (RES_W'(rem_reg[g]) <= (res_reg[g] << 1)))
            else $error("square root lane left an oversized remainder");
    end

    // the root weight was one on the last root digit and is zero when the totals are formed
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.total_en |-> (one_reg == '0 && $past(one_reg) == RES_W'(1)))
        else $error("root iteration count does not match the radicand width");

    // a delivered word is shown on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> out_valid_reg)
        else $error("loaded result word not presented");

endmodule

// ===== hdl/biased_block_palette_quantizer_core.sv =====
// top level of the biased 2x2 block palette quantizer
// depends on bbpq_pkg, bbpq_ctrl and bbpq_datapath
//
//  channel   handshake             payload
//  -------   -------------------   ---------------------------------------------------
//  input     in_valid / in_stall   four pixels, block_column, block_row, frame_start
//  output    out_valid/out_stall   color_code, byte_index, bit_shift, biased_error
//  config    cfg_write             cfg_index, cfg_data (palette colors 0..3)
//
// each word runs from acceptance to the next acceptance through accept, distance (one
// pixel against all four colors per step), square root digits, total and deliver; the
// square root is an 11-step restoring run per palette lane
// the next word is taken while a finished result waits; delivery of the following one
// waits on out_stall; reset is asynchronous, active low, and restores the palette
// defaults and clears the usage counters; no clearing pass is needed

module biased_block_palette_quantizer_core
    import bbpq_pkg::*;
#(
    parameter int BLOCKS_PER_ROW = 128
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic [1:0]           cfg_index,
    input  logic [RGB_W-1:0]     cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [RGB_W-1:0]     pixel_top_left,
    input  logic [RGB_W-1:0]     pixel_top_right,
    input  logic [RGB_W-1:0]     pixel_bottom_left,
    input  logic [RGB_W-1:0]     pixel_bottom_right,
    input  logic [COORD_W-1:0]   block_column,
    input  logic [COORD_W-1:0]   block_row,
    input  logic                 frame_start,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [CODE_W-1:0]    color_code,
    output logic [BYTE_W-1:0]    byte_index,
    output logic [SHIFT_W-1:0]   bit_shift,
    output logic [ERR_W-1:0]     biased_error
);

    dp_cmd_t    cmd;
    dp_status_t status;

    // sequencer
    bbpq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    // arithmetic and storage
    bbpq_datapath #(
        .BLOCKS_PER_ROW (BLOCKS_PER_ROW)
    ) u_datapath (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_write          (cfg_write),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .pixel_top_left     (pixel_top_left),
        .pixel_top_right    (pixel_top_right),
        .pixel_bottom_left  (pixel_bottom_left),
        .pixel_bottom_right (pixel_bottom_right),
        .block_column       (block_column),
        .block_row          (block_row),
        .frame_start        (frame_start),
        .cmd                (cmd),
        .status             (status),
        .out_stall          (out_stall),
        .out_valid          (out_valid),
        .color_code         (color_code),
        .byte_index         (byte_index),
        .bit_shift          (bit_shift),
        .biased_error       (biased_error)
    );

endmodule

// ===== bench/biased_block_palette_quantizer_core_test.sv =====
// self-checking bench for biased_block_palette_quantizer_core
// depends on bbpq_pkg and the core rtl; predicts untyped words from its own palette model

module biased_block_palette_quantizer_core_test;
    import bbpq_pkg::*;

    localparam int ROW_BLOCKS = 128;
    localparam int FRAME_BLOCKS = 128 * 96;
    localparam int IDLE_LIMIT = 2000;
    localparam int TAIL_CYCLES = 40;
    localparam int PHASE_WORDS = 220;
    localparam int BIAS_WORDS = 200;
    localparam int unsigned ERR_TOP = (1 << ERR_W) - 1;

    // palette register indexes
    localparam logic [1:0] REG_PALETTE_0 = 2'd0;
    localparam logic [1:0] REG_PALETTE_1 = 2'd1;
    localparam logic [1:0] REG_PALETTE_2 = 2'd2;
    localparam logic [1:0] REG_PALETTE_3 = 2'd3;
    localparam logic [1:0] PALETTE_REG [NUM_COLORS] = '{
        REG_PALETTE_0, REG_PALETTE_1, REG_PALETTE_2, REG_PALETTE_3
    };

    // color codes under the power-up palette
    localparam logic [CODE_W-1:0] CODE_GREEN = 2'd0;
    localparam logic [CODE_W-1:0] CODE_YELLOW = 2'd1;
    localparam logic [CODE_W-1:0] CODE_BLUE = 2'd2;
    localparam logic [CODE_W-1:0] CODE_RED = 2'd3;

    localparam rgb_t GREEN = 24'h00FF00;
    localparam rgb_t YELLOW = 24'hFFFF00;
    localparam rgb_t BLUE = 24'h0000FF;
    localparam rgb_t RED = 24'hFF0000;
    localparam rgb_t BLACK = 24'h000000;
    localparam rgb_t WHITE = 24'hFFFFFF;
    localparam rgb_t POWER_UP_PALETTE [NUM_COLORS] = '{GREEN, YELLOW, BLUE, RED};

    typedef struct packed {
        logic [NUM_PIXELS-1:0][RGB_W-1:0] px;
        logic [COORD_W-1:0]               col;
        logic [COORD_W-1:0]               row;
        logic                             frame;
    } block_word_t;

    typedef struct packed {
        logic [CODE_W-1:0]  code;
        logic [BYTE_W-1:0]  byte_idx;
        logic [SHIFT_W-1:0] shift;
        logic [ERR_W-1:0]   err;
    } quant_word_t;

    typedef struct packed {
        block_word_t blk;
        logic        typed;
        quant_word_t want;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_write;
    logic [1:0] cfg_index;
    logic [RGB_W-1:0] cfg_data;
    logic in_valid;
    logic in_stall;
    logic out_valid;
    logic out_stall;
    block_word_t drive;
    logic cur_typed;
    quant_word_t cur_want;
    logic [CODE_W-1:0] color_code;
    logic [BYTE_W-1:0] byte_index;
    logic [SHIFT_W-1:0] bit_shift;
    logic [ERR_W-1:0] biased_error;

    // predictor state
    rgb_t palette_now [NUM_COLORS];
    logic [CNT_W-1:0] usage_count [NUM_COLORS];
    quant_word_t pending_words [$];
    stim_row_t directed_rows [$];

    int mismatches = 0;
    int idle_cycles = 0;
    int stall_run = 0;
    int scan_pos = 0;
    bit idling = 1'b0;

    always #10 clk = ~clk;

    biased_block_palette_quantizer_core #(
        .BLOCKS_PER_ROW(ROW_BLOCKS)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .pixel_top_left(drive.px[0]),
        .pixel_top_right(drive.px[1]),
        .pixel_bottom_left(drive.px[2]),
        .pixel_bottom_right(drive.px[3]),
        .block_column(drive.col),
        .block_row(drive.row),
        .frame_start(drive.frame),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .color_code(color_code),
        .byte_index(byte_index),
        .bit_shift(bit_shift),
        .biased_error(biased_error)
    );

    // integer square root rounded to nearest
    function automatic int unsigned nearest_root(input int unsigned d);
        int unsigned r;
        int unsigned t;
        int b;
        r = 0;
        for (b = 10; b >= 0; b--)
        begin
            t = r | (32'd1 << b);
            if (t * t <= d)
                r = t;
        end
        if (d - r * r > r)
            r++;
        return r;
    endfunction

    // pick the palette entry for one block and bump its usage count
    function automatic quant_word_t quantize_block(input block_word_t b);
        quant_word_t w;
        int unsigned dist_sum;
        int unsigned total;
        int unsigned best_total;
        int unsigned pos;
        int unsigned pix_ch;
        int unsigned pal_ch;
        int unsigned diff;
        int best;
        int p;
        int c;
        int k;
        if (b.frame)
            for (p = 0; p < NUM_COLORS; p++)
                usage_count[p] = '0;
        best = 0;
        best_total = 0;
        for (p = 0; p < NUM_COLORS; p++)
        begin
            dist_sum = 0;
            for (c = 0; c < NUM_CHANNELS; c++)
            begin
                pal_ch = palette_now[p][8*c +: 8];
                for (k = 0; k < NUM_PIXELS; k++)
                begin
                    pix_ch = b.px[k][8*c +: 8];
                    diff = (pix_ch >= pal_ch) ? pix_ch - pal_ch : pal_ch - pix_ch;
                    dist_sum += diff * diff;
                end
            end
            total = nearest_root(dist_sum) + (int'(usage_count[p]) >> BIAS_SHIFT);
            if (p == 0 || total < best_total)
            begin
                best_total = total;
                best = p;
            end
        end
        pos = int'(b.row) * ROW_BLOCKS + int'(b.col);
        w.code = CODE_W'(best);
        w.byte_idx = BYTE_W'(pos >> 2);
        w.shift = SHIFT_W'(((pos & 3) ^ 3) << 1);
        w.err = (best_total > ERR_TOP) ? ERR_W'(ERR_TOP) : ERR_W'(best_total);
        if (usage_count[best] != CNT_MAX)
            usage_count[best] = usage_count[best] + 1'b1;
        return w;
    endfunction

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 19);
        if (r < 15)
            return $urandom_range(1, 3);
        else if (r < 19)
            return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    // color near a base, each channel clamped
    function automatic rgb_t noisy_rgb(input rgb_t base, input int spread);
        rgb_t v;
        int c;
        int ch;
        for (c = 0; c < NUM_CHANNELS; c++)
        begin
            ch = int'(base[8*c +: 8]) + int'($urandom_range(0, 2 * spread)) - spread;
            if (ch < 0)
                ch = 0;
            if (ch > 255)
                ch = 255;
            v[8*c +: 8] = ch[7:0];
        end
        return v;
    endfunction

    // random block: mostly near one palette entry, scanning positions in order
    function automatic block_word_t random_block();
        block_word_t b;
        int base;
        int spread;
        int k;
        int c;
        int r;
        base = $urandom_range(0, NUM_COLORS - 1);
        spread = ($urandom_range(0, 3) == 0) ? 64 : 6;
        for (k = 0; k < NUM_PIXELS; k++)
        begin
            r = $urandom_range(0, 9);
            if (r < 5)
                b.px[k] = noisy_rgb(palette_now[base], spread);
            else if (r < 7)
                b.px[k] = rgb_t'($urandom);
            else if (r == 7)
                for (c = 0; c < NUM_CHANNELS; c++)
                    b.px[k][8*c +: 8] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            else
                b.px[k] = noisy_rgb(palette_now[$urandom_range(0, NUM_COLORS - 1)], 40);
        end
        if ($urandom_range(0, 4) != 0)
        begin
            b.col = COORD_W'(scan_pos % ROW_BLOCKS);
            b.row = COORD_W'((scan_pos / ROW_BLOCKS) % 96);
            b.frame = (scan_pos % FRAME_BLOCKS == 0) || ($urandom_range(0, 149) == 0);
            scan_pos++;
        end
        else
        begin
            b.col = COORD_W'($urandom_range(0, 127));
            b.row = COORD_W'($urandom_range(0, 127));
            b.frame = ($urandom_range(0, 149) == 0);
        end
        return b;
    endfunction

    function automatic void add_row(input rgb_t tl, input rgb_t tr, input rgb_t bl,
                                    input rgb_t br, input int col, input int row,
                                    input logic frame, input logic typed,
                                    input logic [CODE_W-1:0] code = '0,
                                    input int byte_idx = 0, input int shift = 0,
                                    input int err = 0);
        stim_row_t s;
        s.blk.px[0] = tl;
        s.blk.px[1] = tr;
        s.blk.px[2] = bl;
        s.blk.px[3] = br;
        s.blk.col = COORD_W'(col);
        s.blk.row = COORD_W'(row);
        s.blk.frame = frame;
        s.typed = typed;
        s.want.code = code;
        s.want.byte_idx = BYTE_W'(byte_idx);
        s.want.shift = SHIFT_W'(shift);
        s.want.err = ERR_W'(err);
        directed_rows.push_back(s);
    endfunction

    task automatic report(input string msg);
        if (mismatches < 40)
            $display("mismatch: %s", msg);
        mismatches++;
    endtask

    // present one word and hold it until taken
    task automatic send_word(input block_word_t b, input logic typed, input quant_word_t want);
        int gap;
        gap = (idling && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        drive <= b;
        cur_typed <= typed;
        cur_want <= want;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // step past the current edge first so a word taken at it is already pending
    task automatic wait_drained();
        @(posedge clk);
        while (pending_words.size() != 0)
            @(posedge clk);
    endtask

    // write all four palette registers back to back
    task automatic set_palette(input rgb_t colors [NUM_COLORS]);
        int i;
        for (i = 0; i < NUM_COLORS; i++)
        begin
            cfg_write <= 1'b1;
            cfg_index <= PALETTE_REG[i];
            cfg_data <= colors[i];
            palette_now[i] = colors[i];
            @(posedge clk);
        end
        cfg_write <= 1'b0;
    endtask

    // result stall with random gaps
    always @(posedge clk)
    begin
        if (!idling || stall_run == 0)
        begin
            out_stall <= 1'b0;
            if (idling && $urandom_range(0, 4) == 0)
                stall_run = pick_gap();
        end
        else
        begin
            out_stall <= 1'b1;
            stall_run = stall_run - 1;
        end
    end

    // check delivered words, then predict newly accepted ones
    always @(posedge clk)
    begin : check_words
        quant_word_t want;
        quant_word_t got;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (pending_words.size() == 0)
                    report("result word with nothing pending");
                else
                begin
                    want = pending_words.pop_front();
                    if (color_code !== want.code)
                        report($sformatf("color_code got %0d want %0d", color_code, want.code));
                    if (byte_index !== want.byte_idx)
                        report($sformatf("byte_index got %0d want %0d",
                                         byte_index, want.byte_idx));
                    if (bit_shift !== want.shift)
                        report($sformatf("bit_shift got %0d want %0d", bit_shift, want.shift));
                    if (biased_error !== want.err)
                        report($sformatf("biased_error got %0d want %0d",
                                         biased_error, want.err));
                end
            end
            if (in_valid && !in_stall)
            begin
                got = quantize_block(drive);
                pending_words.push_back(cur_typed ? cur_want : got);
            end
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("status: fail");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin : stimulus
        rgb_t colors [NUM_COLORS];
        block_word_t b;
        rgb_t base;
        int phase;
        int n;
        int i;
        int k;

        rst_n <= 1'b0;
        cfg_write <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        in_valid <= 1'b0;
        drive <= '0;
        cur_typed <= 1'b0;
        cur_want <= '0;
        out_stall <= 1'b0;
        for (i = 0; i < NUM_COLORS; i++)
        begin
            palette_now[i] = POWER_UP_PALETTE[i];
            usage_count[i] = '0;
        end

        // directed words under the power-up palette
        add_row(GREEN, GREEN, GREEN, GREEN, 0, 0, 1'b1, 1'b1, CODE_GREEN, 0, 6, 0);
        add_row(YELLOW, YELLOW, YELLOW, YELLOW, 1, 0, 1'b0, 1'b1, CODE_YELLOW, 0, 4, 0);
        add_row(BLUE, BLUE, BLUE, BLUE, 2, 0, 1'b0, 1'b1, CODE_BLUE, 0, 2, 0);
        add_row(RED, RED, RED, RED, 3, 0, 1'b0, 1'b1, CODE_RED, 0, 0, 0);
        add_row(BLUE, BLUE, BLUE, BLUE, 127, 127, 1'b0, 1'b1, CODE_BLUE, 4095, 0, 0);
        // three-way tie on black, lowest index wins
        add_row(BLACK, BLACK, BLACK, BLACK, 0, 95, 1'b0, 1'b0);
        add_row(WHITE, WHITE, WHITE, WHITE, 127, 95, 1'b0, 1'b0);
        add_row(WHITE, BLACK, GREEN, 24'hFF00FF, 64, 48, 1'b0, 1'b0);
        add_row(24'h7F7F7F, 24'h808080, 24'h7F7F7F, 24'h808080, 10, 3, 1'b0, 1'b0);
        // rounding down, then up
        add_row(24'h02FF00, 24'h01FF01, GREEN, GREEN, 11, 3, 1'b0, 1'b0);
        add_row(24'h02FF00, 24'h01FF01, 24'h00FE00, GREEN, 12, 3, 1'b0, 1'b0);
        // frame start clears the bias
        add_row(GREEN, GREEN, GREEN, GREEN, 5, 2, 1'b1, 1'b1, CODE_GREEN, 65, 4, 0);
        // row beyond the frame
        add_row(24'h123456, 24'hABCDEF, GREEN, 24'hFEDCBA, 99, 120, 1'b0, 1'b0);
        add_row(24'hFFFF01, 24'hFE0000, 24'h0100FE, 24'h00FEFF, 126, 1, 1'b0, 1'b0);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < directed_rows.size(); i++)
            send_word(directed_rows[i].blk, directed_rows[i].typed, directed_rows[i].want);
        in_valid <= 1'b0;

        // random phases, each under a new palette
        for (phase = 0; phase < 7; phase++)
        begin
            wait_drained();
            base = rgb_t'($urandom);
            for (i = 0; i < NUM_COLORS; i++)
            begin
                case (phase)
                    0: colors[i] = BLACK;
                    1: colors[i] = WHITE;
                    2: colors[i] = i[0] ? WHITE : BLACK;
                    3, 5: colors[i] = rgb_t'($urandom);
                    default: colors[i] = noisy_rgb(base, 12);
                endcase
            end
            set_palette(colors);
            for (n = 0; n < PHASE_WORDS; n++)
            begin
                if (n % 50 == 0)
                    idling = ($urandom_range(0, 3) != 0);
                send_word(random_block(), 1'b0, '0);
            end
            in_valid <= 1'b0;
        end

        // long run on one color to build up a large usage bias
        wait_drained();
        colors = '{BLACK, WHITE, WHITE, WHITE};
        set_palette(colors);
        idling = 1'b0;
        for (n = 0; n < BIAS_WORDS; n++)
        begin
            for (k = 0; k < NUM_PIXELS; k++)
                b.px[k] = noisy_rgb(BLACK, 3);
            b.col = COORD_W'(n % ROW_BLOCKS);
            b.row = COORD_W'((n / ROW_BLOCKS) % 96);
            b.frame = (n == 0);
            send_word(b, 1'b0, '0);
        end
        in_valid <= 1'b0;

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/bbpq_pkg.sv
hdl/bbpq_ctrl.sv
hdl/bbpq_datapath.sv
hdl/biased_block_palette_quantizer_core.sv
bench/biased_block_palette_quantizer_core_test.sv
